// ----- rtl/lcit_pkg.sv -----
// Shared widths, constants and payload types for the line/circle hit test.
// No dependencies; every other file of the block but lcit_out_if uses this package.
`default_nettype none

package lcit_pkg;

    // Field widths of the item
    localparam int CoordW  = 24;   // Q16.8 coordinates and radius
    localparam int SlopeW  = 32;   // Q16.16 gradient
    localparam int OffsetW = 32;   // Q24.8 intercept

    // Width of one partial product operand in the wide multipliers
    localparam int ChunkW = 32;
    // Register stages through one wide multiplier
    localparam int MulLat = 3;

    // Intermediate widths, sized so that nothing wraps
    localparam int DiffW = CoordW + 1;        // difference of two coordinates
    localparam int EW    = OffsetW + 2;       // intercept minus centre y
    localparam int GeW   = SlopeW + EW;       // gradient times EW
    localparam int SqW   = 2 * DiffW;         // square of a coordinate difference
    localparam int RrW   = 2 * CoordW;        // radius squared
    localparam int GgW   = 2 * SlopeW;        // gradient squared
    localparam int EeW   = 64;                // EW squared, value below 2^63
    localparam int UW    = 82;                // linear term, Q.40
    localparam int KW    = 64;                // 1 + g^2, Q.32
    localparam int WW    = 66;                // constant term, Q.16
    localparam int DW    = 162;               // discriminant, Q.80
    localparam int TW    = 90;                // root bound terms
    localparam int TsqW  = 2 * TW;            // squares of the bound terms

    // Alignment shifts of the Q formats
    localparam int AShift  = 32;              // centre x into the linear term
    localparam int GeShift = 16;              // gradient product into the linear term
    localparam int WkShift = 32;              // constant term product into D

    localparam logic [KW-1:0] KOne = KW'(64'h0000_0001_0000_0000);

    typedef struct packed {
        logic                      alive;
        logic signed [CoordW-1:0]  center_x;
        logic signed [CoordW-1:0]  center_y;
        logic signed [CoordW-1:0]  circle_radius;
        logic signed [CoordW-1:0]  start_x;
        logic signed [CoordW-1:0]  start_y;
        logic signed [CoordW-1:0]  end_x;
        logic signed [CoordW-1:0]  end_y;
        logic signed [SlopeW-1:0]  slope;
        logic signed [OffsetW-1:0] offset_y;
    } lcit_item_t;

    // Front half to back half of the pipeline
    typedef struct packed {
        logic                 valid;
        logic                 kill;
        logic                 vert;
        logic                 short_hit;
        logic signed [UW-1:0] u;
        logic [UW-1:0]        umag;
        logic [KW-1:0]        k;
        logic [WW-1:0]        wmag;
        logic                 wneg;
        logic [CoordW-1:0]    lomag;
        logic                 loneg;
        logic [CoordW-1:0]    himag;
        logic                 hineg;
    } lcit_mid_t;

endpackage

`default_nettype wire

// ----- rtl/lcit_in_if.sv -----
// Input channel of the hit test: valid/ready plus one item's fields.
// Depends on lcit_pkg for field widths.
`default_nettype none

interface lcit_in_if;
    logic                               valid;
    logic                               ready;
    logic                               alive;
    logic signed [lcit_pkg::CoordW-1:0]  center_x;
    logic signed [lcit_pkg::CoordW-1:0]  center_y;
    logic signed [lcit_pkg::CoordW-1:0]  circle_radius;
    logic signed [lcit_pkg::CoordW-1:0]  start_x;
    logic signed [lcit_pkg::CoordW-1:0]  start_y;
    logic signed [lcit_pkg::CoordW-1:0]  end_x;
    logic signed [lcit_pkg::CoordW-1:0]  end_y;
    logic signed [lcit_pkg::SlopeW-1:0]  slope;
    logic signed [lcit_pkg::OffsetW-1:0] offset_y;

    modport source (
        output valid, alive, center_x, center_y, circle_radius,
               start_x, start_y, end_x, end_y, slope, offset_y,
        input  ready
    );

    modport sink (
        input  valid, alive, center_x, center_y, circle_radius,
               start_x, start_y, end_x, end_y, slope, offset_y,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/lcit_out_if.sv -----
// Result channel of the hit test: valid/ready plus the hit flag.
// No dependencies.
`default_nettype none

interface lcit_out_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (
        output valid, hit,
        input  ready
    );

    modport sink (
        input  valid, hit,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/lcit_umul.sv -----
// Unsigned wide multiplier built from 32x32 partial products, three stages.
// Depends on lcit_pkg for the chunk width.
`default_nettype none

module lcit_umul #(
    parameter int WA = 32,
    parameter int WB = 32
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WA-1:0]    a,
    input  logic [WB-1:0]    b,
    output logic [WA+WB-1:0] p
);
    localparam int CW = lcit_pkg::ChunkW;
    localparam int NA = (WA + CW - 1) / CW;
    localparam int NB = (WB + CW - 1) / CW;
    localparam int RW = CW * (NB + 1);
    localparam int PW = WA + WB;

    logic [NA*CW-1:0] a_pad;
    logic [NB*CW-1:0] b_pad;

    logic [NA-1:0][NB-1:0][2*CW-1:0] pp_reg, pp_next;
    logic [NA-1:0][RW-1:0]           row_reg, row_next;
    logic [PW-1:0]                   p_reg, p_next;

    assign a_pad = (NA*CW)'(a);
    assign b_pad = (NB*CW)'(b);

    // partial products
    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                pp_next[i][j] = (2*CW)'(a_pad[i*CW +: CW]) * (2*CW)'(b_pad[j*CW +: CW]);
            end
        end
    end

    // one row per chunk of a
    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < NB; j++)
            begin
                row_next[i] = row_next[i] + (RW'(pp_reg[i][j]) << (j*CW));
            end
        end
    end

    // add the rows
    always_comb
    begin
        p_next = '0;
        for (int i = 0; i < NA; i++)
        begin
            p_next = p_next + (PW'(row_reg[i]) << (i*CW));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_reg  <= pp_next;
            row_reg <= row_next;
            p_reg   <= p_next;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ----- rtl/lcit_front.sv -----
// Front half of the hit test: differences, narrow products, the quadratic's
// terms and the vertical/point decisions, over four stages. Uses lcit_pkg.
`default_nettype none

module lcit_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  lcit_pkg::lcit_item_t in_item,
    output lcit_pkg::lcit_mid_t  mid
);
    localparam int CoordW  = lcit_pkg::CoordW;
    localparam int SlopeW  = lcit_pkg::SlopeW;
    localparam int DiffW   = lcit_pkg::DiffW;
    localparam int EW      = lcit_pkg::EW;
    localparam int GeW     = lcit_pkg::GeW;
    localparam int SqW     = lcit_pkg::SqW;
    localparam int RrW     = lcit_pkg::RrW;
    localparam int GgW     = lcit_pkg::GgW;
    localparam int EeW     = lcit_pkg::EeW;
    localparam int UW      = lcit_pkg::UW;
    localparam int KW      = lcit_pkg::KW;
    localparam int WW      = lcit_pkg::WW;
    localparam int CmpW    = SqW + 1;

    typedef struct packed {
        logic                     valid;
        logic                     kill;
        logic                     vert;
        logic                     point;
        logic signed [CoordW-1:0] a;
        logic signed [EW-1:0]     e;
        logic signed [SlopeW-1:0] g;
        logic signed [CoordW-1:0] r;
        logic signed [CoordW-1:0] lo;
        logic signed [CoordW-1:0] hi;
        logic signed [DiffW-1:0]  dx;
        logic signed [DiffW-1:0]  dy;
        logic signed [DiffW-1:0]  t1;
        logic signed [DiffW-1:0]  t2;
    } s1_t;

    typedef struct packed {
        logic                     valid;
        logic                     kill;
        logic                     vert;
        logic                     point;
        logic signed [CoordW-1:0] a;
        logic signed [CoordW-1:0] lo;
        logic signed [CoordW-1:0] hi;
        logic signed [GeW-1:0]    ge;
        logic [GgW-1:0]           gg;
        logic [RrW-1:0]           aa;
        logic [EeW-1:0]           ee;
        logic [RrW-1:0]           rr;
        logic [SqW-1:0]           dxsq;
        logic [SqW-1:0]           dysq;
        logic [SqW-1:0]           t1sq;
        logic [SqW-1:0]           t2sq;
        logic                     t1neg;
        logic                     t2neg;
    } s2_t;

    typedef struct packed {
        logic                     valid;
        logic                     kill;
        logic                     vert;
        logic                     short_hit;
        logic signed [CoordW-1:0] lo;
        logic signed [CoordW-1:0] hi;
        logic signed [UW-1:0]     u;
        logic [KW-1:0]            k;
        logic signed [WW-1:0]     w;
    } s3_t;

    s1_t                 s1_reg, s1_next;
    s2_t                 s2_reg, s2_next;
    s3_t                 s3_reg, s3_next;
    lcit_pkg::lcit_mid_t mid_reg, mid_next;

    // stage 1: differences and interval ends
    always_comb
    begin
        s1_next       = '0;
        s1_next.valid = in_valid;
        s1_next.kill  = !in_item.alive || in_item.circle_radius[CoordW-1];
        s1_next.vert  = (in_item.start_x == in_item.end_x);
        s1_next.point = (in_item.start_y == in_item.end_y);
        s1_next.a     = in_item.center_x;
        s1_next.e     = EW'(in_item.offset_y) - EW'(in_item.center_y);
        s1_next.g     = in_item.slope;
        s1_next.r     = in_item.circle_radius;
        s1_next.dx    = DiffW'(in_item.start_x) - DiffW'(in_item.center_x);
        s1_next.dy    = DiffW'(in_item.start_y) - DiffW'(in_item.center_y);
        if (in_item.start_x < in_item.end_x)
        begin
            s1_next.lo = in_item.start_x;
            s1_next.hi = in_item.end_x;
        end
        else
        begin
            s1_next.lo = in_item.end_x;
            s1_next.hi = in_item.start_x;
        end
        if (in_item.start_y < in_item.end_y)
        begin
            s1_next.t1 = DiffW'(in_item.start_y) - DiffW'(in_item.center_y);
            s1_next.t2 = DiffW'(in_item.center_y) - DiffW'(in_item.end_y);
        end
        else
        begin
            s1_next.t1 = DiffW'(in_item.end_y) - DiffW'(in_item.center_y);
            s1_next.t2 = DiffW'(in_item.center_y) - DiffW'(in_item.start_y);
        end
    end

    // stage 2: narrow products
    always_comb
    begin
        s2_next       = '0;
        s2_next.valid = s1_reg.valid;
        s2_next.kill  = s1_reg.kill;
        s2_next.vert  = s1_reg.vert;
        s2_next.point = s1_reg.point;
        s2_next.a     = s1_reg.a;
        s2_next.lo    = s1_reg.lo;
        s2_next.hi    = s1_reg.hi;
        s2_next.ge    = GeW'(s1_reg.g) * GeW'(s1_reg.e);
        s2_next.gg    = GgW'(s1_reg.g) * GgW'(s1_reg.g);
        s2_next.aa    = RrW'(s1_reg.a) * RrW'(s1_reg.a);
        s2_next.ee    = EeW'(s1_reg.e) * EeW'(s1_reg.e);
        s2_next.rr    = RrW'(s1_reg.r) * RrW'(s1_reg.r);
        s2_next.dxsq  = SqW'(s1_reg.dx) * SqW'(s1_reg.dx);
        s2_next.dysq  = SqW'(s1_reg.dy) * SqW'(s1_reg.dy);
        s2_next.t1sq  = SqW'(s1_reg.t1) * SqW'(s1_reg.t1);
        s2_next.t2sq  = SqW'(s1_reg.t2) * SqW'(s1_reg.t2);
        s2_next.t1neg = s1_reg.t1[DiffW-1];
        s2_next.t2neg = s1_reg.t2[DiffW-1];
    end

    // stage 3: quadratic terms, and the whole answer for vertical and point
    always_comb
    begin
        logic signed [UW-1:0] ua;
        logic signed [UW-1:0] ub;
        logic [CmpW-1:0]      rr_c;
        logic [CmpW-1:0]      dx_c;
        logic                 pt_hit;
        logic                 vt_hit;

        ua   = UW'(s2_reg.a);
        ub   = UW'(s2_reg.ge);
        rr_c = CmpW'(s2_reg.rr);
        dx_c = CmpW'(s2_reg.dxsq);

        pt_hit = (dx_c + CmpW'(s2_reg.dysq)) <= rr_c;
        // chord must reach strictly past both ends' offsets
        vt_hit = (rr_c >= dx_c)
                 && (s2_reg.t1neg || rr_c > dx_c + CmpW'(s2_reg.t1sq))
                 && (s2_reg.t2neg || rr_c > dx_c + CmpW'(s2_reg.t2sq));

        s3_next           = '0;
        s3_next.valid     = s2_reg.valid;
        s3_next.kill      = s2_reg.kill;
        s3_next.vert      = s2_reg.vert;
        s3_next.short_hit = s2_reg.point ? pt_hit : vt_hit;
        s3_next.lo        = s2_reg.lo;
        s3_next.hi        = s2_reg.hi;
        s3_next.u         = (ua <<< lcit_pkg::AShift) - (ub <<< lcit_pkg::GeShift);
        s3_next.k         = KW'(s2_reg.gg) + lcit_pkg::KOne;
        s3_next.w         = WW'(s2_reg.aa) + WW'(s2_reg.ee) - WW'(s2_reg.rr);
    end

    // stage 4: magnitudes and signs for the unsigned multipliers
    always_comb
    begin
        mid_next           = '0;
        mid_next.valid     = s3_reg.valid;
        mid_next.kill      = s3_reg.kill;
        mid_next.vert      = s3_reg.vert;
        mid_next.short_hit = s3_reg.short_hit;
        mid_next.u         = s3_reg.u;
        mid_next.umag      = s3_reg.u[UW-1] ? UW'(-s3_reg.u) : UW'(s3_reg.u);
        mid_next.k         = s3_reg.k;
        mid_next.wneg      = s3_reg.w[WW-1];
        mid_next.wmag      = s3_reg.w[WW-1] ? WW'(-s3_reg.w) : WW'(s3_reg.w);
        mid_next.loneg     = s3_reg.lo[CoordW-1];
        mid_next.lomag     = s3_reg.lo[CoordW-1] ? CoordW'(-s3_reg.lo) : CoordW'(s3_reg.lo);
        mid_next.hineg     = s3_reg.hi[CoordW-1];
        mid_next.himag     = s3_reg.hi[CoordW-1] ? CoordW'(-s3_reg.hi) : CoordW'(s3_reg.hi);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg  <= '0;
            s2_reg  <= '0;
            s3_reg  <= '0;
            mid_reg <= '0;
        end
        else if (en)
        begin
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            s3_reg  <= s3_next;
            mid_reg <= mid_next;
        end
    end

    assign mid = mid_reg;

endmodule

`default_nettype wire

// ----- rtl/lcit_back.sv -----
// Back half of the hit test: wide products, discriminant and root bounds,
// their squares and the final compare. Uses lcit_pkg and lcit_umul.
`default_nettype none

module lcit_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  lcit_pkg::lcit_mid_t mid,
    output logic                out_valid,
    output logic                out_hit
);
    localparam int CoordW = lcit_pkg::CoordW;
    localparam int UW     = lcit_pkg::UW;
    localparam int KW     = lcit_pkg::KW;
    localparam int WW     = lcit_pkg::WW;
    localparam int DW     = lcit_pkg::DW;
    localparam int TW     = lcit_pkg::TW;
    localparam int TsqW   = lcit_pkg::TsqW;
    localparam int MulLat = lcit_pkg::MulLat;

    typedef struct packed {
        logic                 valid;
        logic                 kill;
        logic                 vert;
        logic                 short_hit;
        logic signed [UW-1:0] u;
        logic                 wneg;
        logic                 loneg;
        logic                 hineg;
    } side1_t;

    typedef struct packed {
        logic                 valid;
        logic                 kill;
        logic                 vert;
        logic                 short_hit;
        logic signed [DW-1:0] d;
        logic signed [TW-1:0] t1;
        logic signed [TW-1:0] t2;
    } comb_t;

    typedef struct packed {
        logic                 valid;
        logic                 kill;
        logic                 vert;
        logic                 short_hit;
        logic                 dneg;
        logic                 t1pos;
        logic                 t2pos;
        logic signed [DW-1:0] d;
    } side2_t;

    typedef struct packed {
        logic                 valid;
        logic                 kill;
        logic                 vert;
        logic                 short_hit;
        logic                 dneg;
        logic                 t1pos;
        logic                 t2pos;
        logic signed [DW-1:0] d;
        logic [TW-1:0]        t1mag;
        logic [TW-1:0]        t2mag;
    } mag_t;

    side1_t side1_reg [MulLat];
    side1_t side1_in;
    side2_t side2_reg [MulLat];
    side2_t side2_in;
    comb_t  comb_reg, comb_next;
    mag_t   mag_reg, mag_next;
    logic   valid_reg, valid_next;
    logic   hit_reg, hit_next;

    logic [2*UW-1:0]       uu_p;
    logic [WW+KW-1:0]      wk_p;
    logic [CoordW+KW-1:0]  lok_p;
    logic [CoordW+KW-1:0]  hik_p;
    logic [TsqW-1:0]       t1sq_p;
    logic [TsqW-1:0]       t2sq_p;

    lcit_umul #(.WA(UW), .WB(UW)) u_uu (
        .clk (clk), .en (en), .a (mid.umag), .b (mid.umag), .p (uu_p)
    );

    lcit_umul #(.WA(WW), .WB(KW)) u_wk (
        .clk (clk), .en (en), .a (mid.wmag), .b (mid.k), .p (wk_p)
    );

    lcit_umul #(.WA(CoordW), .WB(KW)) u_lok (
        .clk (clk), .en (en), .a (mid.lomag), .b (mid.k), .p (lok_p)
    );

    lcit_umul #(.WA(CoordW), .WB(KW)) u_hik (
        .clk (clk), .en (en), .a (mid.himag), .b (mid.k), .p (hik_p)
    );

    always_comb
    begin
        side1_in.valid     = mid.valid;
        side1_in.kill      = mid.kill;
        side1_in.vert      = mid.vert;
        side1_in.short_hit = mid.short_hit;
        side1_in.u         = mid.u;
        side1_in.wneg      = mid.wneg;
        side1_in.loneg     = mid.loneg;
        side1_in.hineg     = mid.hineg;
    end

    // discriminant and the two root bound terms, signs put back
    always_comb
    begin
        side1_t               sd;
        logic signed [DW-1:0] d_uu;
        logic signed [DW-1:0] d_wk;
        logic signed [TW-1:0] tu;
        logic signed [TW-1:0] tl;
        logic signed [TW-1:0] th;

        sd   = side1_reg[MulLat-1];
        d_uu = DW'(uu_p);
        d_wk = DW'(wk_p) << lcit_pkg::WkShift;
        tu   = TW'(sd.u);
        tl   = TW'(lok_p);
        th   = TW'(hik_p);

        comb_next.valid     = sd.valid;
        comb_next.kill      = sd.kill;
        comb_next.vert      = sd.vert;
        comb_next.short_hit = sd.short_hit;
        comb_next.d         = sd.wneg  ? d_uu + d_wk : d_uu - d_wk;
        comb_next.t1        = sd.loneg ? -tl - tu : tl - tu;
        comb_next.t2        = sd.hineg ? tu + th : tu - th;
    end

    // magnitudes of the bound terms
    always_comb
    begin
        mag_next.valid     = comb_reg.valid;
        mag_next.kill      = comb_reg.kill;
        mag_next.vert      = comb_reg.vert;
        mag_next.short_hit = comb_reg.short_hit;
        mag_next.dneg      = comb_reg.d[DW-1];
        mag_next.t1pos     = !comb_reg.t1[TW-1] && (comb_reg.t1 != '0);
        mag_next.t2pos     = !comb_reg.t2[TW-1] && (comb_reg.t2 != '0);
        mag_next.d         = comb_reg.d;
        mag_next.t1mag     = comb_reg.t1[TW-1] ? TW'(-comb_reg.t1) : TW'(comb_reg.t1);
        mag_next.t2mag     = comb_reg.t2[TW-1] ? TW'(-comb_reg.t2) : TW'(comb_reg.t2);
    end

    lcit_umul #(.WA(TW), .WB(TW)) u_t1sq (
        .clk (clk), .en (en), .a (mag_reg.t1mag), .b (mag_reg.t1mag), .p (t1sq_p)
    );

    lcit_umul #(.WA(TW), .WB(TW)) u_t2sq (
        .clk (clk), .en (en), .a (mag_reg.t2mag), .b (mag_reg.t2mag), .p (t2sq_p)
    );

    always_comb
    begin
        side2_in.valid     = mag_reg.valid;
        side2_in.kill      = mag_reg.kill;
        side2_in.vert      = mag_reg.vert;
        side2_in.short_hit = mag_reg.short_hit;
        side2_in.dneg      = mag_reg.dneg;
        side2_in.t1pos     = mag_reg.t1pos;
        side2_in.t2pos     = mag_reg.t2pos;
        side2_in.d         = mag_reg.d;
    end

    // both roots must reach the segment's x span
    always_comb
    begin
        side2_t          sd;
        logic [TsqW-1:0] dz;
        logic            sloped;

        sd     = side2_reg[MulLat-1];
        dz     = TsqW'(sd.d);
        sloped = !sd.dneg
                 && (!sd.t1pos || dz >= t1sq_p)
                 && (!sd.t2pos || dz >= t2sq_p);
        valid_next = sd.valid;
        hit_next   = !sd.kill && (sd.vert ? sd.short_hit : sloped);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MulLat; i++)
            begin
                side1_reg[i] <= '0;
                side2_reg[i] <= '0;
            end
            comb_reg  <= '0;
            mag_reg   <= '0;
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else if (en)
        begin
            side1_reg[0] <= side1_in;
            side2_reg[0] <= side2_in;
            for (int i = 1; i < MulLat; i++)
            begin
                side1_reg[i] <= side1_reg[i-1];
                side2_reg[i] <= side2_reg[i-1];
            end
            comb_reg  <= comb_next;
            mag_reg   <= mag_next;
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_hit   = hit_reg;

endmodule

`default_nettype wire

// ----- rtl/line_circle_intersect_test.sv -----
// Line segment versus circle hit test, top level: input packing, the two
// pipeline halves and the output register with skid. Uses lcit_pkg,
// lcit_in_if, lcit_out_if, lcit_front and lcit_back.
//
// One item per clock while the skid register is empty. Each beat on item
// carries a circle and a segment with its line; each beat on result
// carries the hit flag, in the same order. An accepted item beat passes
// through four front stages (differences, narrow products, quadratic
// terms, magnitudes), three stages of wide partial-product multiply, one
// for the discriminant and bound terms, one for their magnitudes, three
// more of wide multiply for the squares, one compare stage, and the
// output register before its result beat is presented. The whole pipeline
// advances together; a skid register behind the output register takes one
// more result while the output is stalled, so item stays ready until both
// are full. All compares are exact, with no rounding and no saturation.
// There is no kept state between items and nothing to configure.
`default_nettype none

module line_circle_intersect_test (
    input  logic       clk,
    input  logic       rst_n,
    lcit_in_if.sink    item,
    lcit_out_if.source result
);
    lcit_pkg::lcit_item_t item_pkt;
    lcit_pkg::lcit_mid_t  mid;

    logic en;
    logic pipe_valid;
    logic pipe_hit;

    logic out_valid_reg, out_valid_next;
    logic out_hit_reg, out_hit_next;
    logic skid_valid_reg, skid_valid_next;
    logic skid_hit_reg, skid_hit_next;

    // advance the pipeline whenever the skid slot is free
    assign en         = !skid_valid_reg;
    assign item.ready = en;

    always_comb
    begin
        item_pkt.alive         = item.alive;
        item_pkt.center_x      = item.center_x;
        item_pkt.center_y      = item.center_y;
        item_pkt.circle_radius = item.circle_radius;
        item_pkt.start_x       = item.start_x;
        item_pkt.start_y       = item.start_y;
        item_pkt.end_x         = item.end_x;
        item_pkt.end_y         = item.end_y;
        item_pkt.slope         = item.slope;
        item_pkt.offset_y      = item.offset_y;
    end

    lcit_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (item.valid),
        .in_item  (item_pkt),
        .mid      (mid)
    );

    lcit_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .mid       (mid),
        .out_valid (pipe_valid),
        .out_hit   (pipe_hit)
    );

    // Output register and skid. While the skid holds a beat the pipeline is
    // frozen, so its last stage keeps the next result until the skid drains.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_hit_next    = out_hit_reg;
        skid_valid_next = skid_valid_reg;
        skid_hit_next   = skid_hit_reg;
        if (skid_valid_reg)
        begin
            if (result.ready)
            begin
                out_valid_next  = 1'b1;
                out_hit_next    = skid_hit_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (out_valid_reg && !result.ready)
        begin
            // hold the output, park the new beat
            if (pipe_valid)
            begin
                skid_valid_next = 1'b1;
                skid_hit_next   = pipe_hit;
            end
        end
        else
        begin
            out_valid_next = pipe_valid;
            out_hit_next   = pipe_hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_hit_reg  <= out_hit_next;
        skid_hit_reg <= skid_hit_next;
    end

    assign result.valid = out_valid_reg;
    assign result.hit   = out_hit_reg;

    // the skid only fills behind a waiting output beat
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a beat while the output register is empty");

    a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !result.ready))
        else $error("skid filled without an output stall");

    a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |=> ($stable(pipe_valid) && $stable(pipe_hit)))
        else $error("pipeline advanced while the skid was full");

endmodule

`default_nettype wire

// ----- tb/sv/tb_lcit_if.sv -----
// Shared item type of the hit-test bench: one segment/circle pair per beat.
// Depends on lcit_pkg for field widths; the RTL supplies lcit_in_if/lcit_out_if.
`timescale 1ns / 1ps

// The block's own interfaces are used as they are; this file keeps the
// bench's shared item type only.
package tb_lcit_types;

    typedef struct {
        logic                                alive;
        logic signed [lcit_pkg::CoordW-1:0]  cx;
        logic signed [lcit_pkg::CoordW-1:0]  cy;
        logic signed [lcit_pkg::CoordW-1:0]  rad;
        logic signed [lcit_pkg::CoordW-1:0]  x1;
        logic signed [lcit_pkg::CoordW-1:0]  y1;
        logic signed [lcit_pkg::CoordW-1:0]  x2;
        logic signed [lcit_pkg::CoordW-1:0]  y2;
        logic signed [lcit_pkg::SlopeW-1:0]  grad;
        logic signed [lcit_pkg::OffsetW-1:0] icpt;
    } seg_circle_t;
endpackage

// ----- tb/sv/tb_line_circle_intersect_test.sv -----
// Self-checking bench for line_circle_intersect_test: directed and random
// segment/circle items, exact wide-integer hit prediction, in-order compare.
// Depends on lcit_pkg, lcit_in_if, lcit_out_if and tb_lcit_types.
`timescale 1ns / 1ps

module tb_line_circle_intersect_test;

    // Wide enough for every intermediate: D is below 2^162 in magnitude.
    typedef logic signed [199:0] big_t;

    // Exact hit prediction, one flag per item.
    function automatic bit predict_hit(tb_lcit_types::seg_circle_t s);
        big_t ax, e, g, r, u, k, w, d, lo, hi, t1, t2;
        longint dx, dy, dv, ymin, ymax, b1, b2;
        bit ok1, ok2;
        if (!s.alive || s.rad < 0)
            return 0;
        if (s.x1 != s.x2)
        begin
            ax = big_t'(s.cx);
            e  = big_t'(s.icpt) - big_t'(s.cy);
            g  = big_t'(s.grad);
            r  = big_t'(s.rad);
            u  = (ax <<< 32) - ((g * e) <<< 16);
            k  = (big_t'(1) <<< 32) + g * g;
            w  = ax * ax + e * e - r * r;
            d  = u * u - ((w * k) <<< 32);
            if (d < 0)
                return 0;
            lo = big_t'((s.x1 < s.x2) ? s.x1 : s.x2);
            hi = big_t'((s.x1 < s.x2) ? s.x2 : s.x1);
            t1 = lo * k - u;
            t2 = u - hi * k;
            ok1 = (t1 <= 0) || (d >= t1 * t1);
            ok2 = (t2 <= 0) || (d >= t2 * t2);
            return ok1 && ok2;
        end
        if (s.y1 == s.y2)
        begin
            dx = longint'(s.cx) - s.x1;
            dy = longint'(s.cy) - s.y1;
            return dx * dx + dy * dy <= longint'(s.rad) * s.rad;
        end
        dx = longint'(s.x1) - s.cx;
        dv = longint'(s.rad) * s.rad - dx * dx;
        if (dv < 0)
            return 0;
        ymin = (s.y1 < s.y2) ? s.y1 : s.y2;
        ymax = (s.y1 < s.y2) ? s.y2 : s.y1;
        b1 = ymin - s.cy;
        b2 = s.cy - ymax;
        ok1 = (b1 < 0) || (dv > b1 * b1);
        ok2 = (b2 < 0) || (dv > b2 * b2);
        return ok1 && ok2;
    endfunction

    // Expected hit flags in issue order.
    class hit_scoreboard;
        bit pending_hits[$];
        int errors;

        function void note_item(tb_lcit_types::seg_circle_t s);
            pending_hits.push_back(predict_hit(s));
        endfunction

        function void check_hit(logic actual);
            bit want;
            if (pending_hits.size() == 0)
            begin
                $error("hit: unexpected result beat, actual %0b", actual);
                errors++;
                return;
            end
            want = pending_hits.pop_front();
            if (actual !== want)
            begin
                $error("hit: expected %0b, actual %0b", want, actual);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    bit   calm = 0;          // no idling in the last part of the run
    hit_scoreboard sb = new();

    lcit_in_if  item();
    lcit_out_if result();

    line_circle_intersect_test u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source)
    );

    always #5 clk = ~clk;

    // Check each result beat at the edge where it is taken.
    always @(posedge clk)
        if (rst_n && result.valid && result.ready)
            sb.check_hit(result.hit);

    // Sink side: ready held high, dropped in random bursts.
    initial
    begin
        int hold;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 9) == 0)
            begin
                hold = $urandom_range(1, 16);
                result.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            result.ready <= 1'b1;
        end
    end

    // Present one beat and hold it until accepted; maybe insert a gap after.
    task automatic send_item(tb_lcit_types::seg_circle_t s);
        int gap;
        item.valid         <= 1'b1;
        item.alive         <= s.alive;
        item.center_x      <= s.cx;
        item.center_y      <= s.cy;
        item.circle_radius <= s.rad;
        item.start_x       <= s.x1;
        item.start_y       <= s.y1;
        item.end_x         <= s.x2;
        item.end_y         <= s.y2;
        item.slope         <= s.grad;
        item.offset_y      <= s.icpt;
        do
            @(posedge clk);
        while (!item.ready);
        sb.note_item(s);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 16);
            item.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid once the stream stops.
    task automatic go_quiet();
        item.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic tb_lcit_types::seg_circle_t mk(bit al, int cx, int cy, int rad,
                                                      int x1, int y1, int x2, int y2,
                                                      int grad, int icpt);
        tb_lcit_types::seg_circle_t s;
        s.alive = al;
        s.cx = 24'(cx);  s.cy = 24'(cy);  s.rad = 24'(rad);
        s.x1 = 24'(x1);  s.y1 = 24'(y1);  s.x2 = 24'(x2);  s.y2 = 24'(y2);
        s.grad = grad;  s.icpt = icpt;
        return s;
    endfunction

    function automatic int rnd_coord();
        case ($urandom_range(0, 3))
            0: return $signed(24'($urandom));
            1: return $signed(24'($urandom)) >>> 12;
            default: return int'($urandom_range(0, 8000)) - 4000;
        endcase
    endfunction

    // Random item, mostly built around the circle so hits and misses mix.
    function automatic tb_lcit_types::seg_circle_t rnd_item();
        tb_lcit_types::seg_circle_t s;
        int kind;
        longint gl;
        s.alive = ($urandom_range(0, 9) != 0);
        s.cx = 24'(rnd_coord());
        s.cy = 24'(rnd_coord());
        s.rad = ($urandom_range(0, 15) == 0) ? 24'($urandom)
                                             : 24'($urandom_range(0, 3000));
        kind = $urandom_range(0, 9);
        s.x1 = s.cx + $signed(24'(int'($urandom_range(0, 8000)) - 4000));
        s.y1 = s.cy + $signed(24'(int'($urandom_range(0, 8000)) - 4000));
        s.x2 = s.cx + $signed(24'(int'($urandom_range(0, 8000)) - 4000));
        s.y2 = s.cy + $signed(24'(int'($urandom_range(0, 8000)) - 4000));
        if (kind == 0)
        begin
            s.x2 = s.x1;                       // vertical segment
        end
        else if (kind == 1)
        begin
            s.x2 = s.x1;                       // single point
            s.y2 = s.y1;
        end
        else if (kind == 2)
        begin
            s.x1 = 24'(rnd_coord());  s.y1 = 24'(rnd_coord());
            s.x2 = 24'(rnd_coord());  s.y2 = 24'(rnd_coord());
        end
        if (kind >= 8)
        begin
            s.grad = $urandom;                 // arbitrary line
            s.icpt = $urandom;
        end
        else if (s.x1 != s.x2)
        begin
            // line roughly through the endpoints, Q16.16 gradient
            gl = ((longint'(s.y2) - s.y1) <<< 16) / (longint'(s.x2) - s.x1);
            s.grad = 32'(gl);
            s.icpt = 32'(longint'(s.y1) - ((longint'(s.grad) * s.x1) >>> 16));
        end
        else
        begin
            s.grad = $urandom;
            s.icpt = $urandom;
        end
        return s;
    endfunction

    initial
    begin
        tb_lcit_types::seg_circle_t dir[$];
        int n;

        // Keep every input known from time zero.
        item.valid = 1'b0;
        item.alive = 1'b0;
        item.center_x = '0;
        item.center_y = '0;
        item.circle_radius = '0;
        item.start_x = '0;
        item.start_y = '0;
        item.end_x = '0;
        item.end_y = '0;
        item.slope = '0;
        item.offset_y = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: dead circle, negative radius, tangent, no roots, vertical
        // strict bounds, single points, extremes of every field.
        dir.push_back(mk(0, 0, 0, 512, -1024, 0, 1024, 0, 0, 0));
        dir.push_back(mk(1, 0, 0, -1, -1024, 0, 1024, 0, 0, 0));
        dir.push_back(mk(1, 0, 0, 256, -1024, 256, 1024, 256, 0, 256));    // tangent
        dir.push_back(mk(1, 0, 0, 256, -1024, 512, 1024, 512, 0, 512));    // no roots
        dir.push_back(mk(1, 0, 0, 256, -1024, 0, 1024, 0, 0, 0));          // crossing
        dir.push_back(mk(1, 0, 0, 256, 256, 0, 1024, 0, 0, 0));            // root at lo
        dir.push_back(mk(1, 0, 0, 256, -1024, 0, -256, 0, 0, 0));          // root at hi
        dir.push_back(mk(1, 0, 0, 256, 300, 0, 1024, 0, 0, 0));            // beyond
        dir.push_back(mk(1, 0, 0, 256, 0, 256, 0, 1024, 0, 0));            // vertical, touch
        dir.push_back(mk(1, 0, 0, 256, 0, 100, 0, 1024, 0, 0));            // vertical, in
        dir.push_back(mk(1, 0, 0, 256, 256, -500, 256, 500, 0, 0));        // vertical tangent
        dir.push_back(mk(1, 0, 0, 256, 300, -500, 300, 500, 0, 0));        // vertical outside
        dir.push_back(mk(1, 0, 0, 256, 256, 0, 256, 0, 0, 0));             // point on circle
        dir.push_back(mk(1, 0, 0, 256, 257, 0, 257, 0, 0, 0));             // point outside
        dir.push_back(mk(1, 0, 0, 0, 0, 0, 0, 0, 0, 0));                   // zero radius
        dir.push_back(mk(1, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, -24'sd8388608,
                         -24'sd8388608, 24'h7FFFFF, 24'h7FFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
        dir.push_back(mk(1, -8388608, -8388608, 8388607, 8388607, -8388608,
                         -8388608, 8388607, 32'h80000000, 32'h80000000));
        dir.push_back(mk(1, -8388608, 8388607, 8388607, -8388608, -8388608,
                         -8388608, 8388607, 0, 0));
        dir.push_back(mk(1, 0, 0, 8388607, 8388607, 8388607, 8388607, 8388607, -1, -1));
        dir.push_back(mk(1, 100, -100, 500, -2000, 50, 2000, 70, 32'h7FFFFFFF, -5));
        dir.push_back(mk(1, 0, 0, 256, -1024, -1024, 1024, 1024, 65536, 0)); // diagonal
        foreach (dir[i])
            send_item(dir[i]);

        // Let the pipeline drain fully once before random traffic.
        item.valid <= 1'b0;
        while (sb.pending_hits.size() != 0)
            @(posedge clk);

        for (n = 0; n < 450; n++)
        begin
            if (n == 380)
                calm = 1;
            send_item(rnd_item());
        end
        go_quiet();

        while (sb.pending_hits.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #2ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
